FILE: rtl/kced_pkg.sv
// Shared constants, codes and types of the key combination event detector.
package kced_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int KEY_BITS    = 16;
  localparam int HELD_W      = 32;
  localparam int ELAPSED_W   = 16;
  localparam int IDX_OUT_W   = 5;
  localparam int IW          = $clog2(MAX_ENTRIES);
  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int XDEPTH      = MAX_ENTRIES - KEY_BITS;
  localparam int XW          = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;

  // configuration port
  localparam int CFG_W  = 16;
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_SHIFT_MASK    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CTRL_MASK     = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ELAPSED_LIMIT = 2'd2;

  localparam logic [KEY_BITS-1:0]  SHIFT_MASK_RST    = 16'h0010;
  localparam logic [KEY_BITS-1:0]  CTRL_MASK_RST     = 16'h0020;
  localparam logic [ELAPSED_W-1:0] ELAPSED_LIMIT_RST = 16'd500;

  // request codes
  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_SCAN     = 1'b1;

  typedef enum logic [2:0] {
    EV_PRESS    = 3'd0,
    EV_HOLD     = 3'd1,
    EV_RELEASE  = 3'd2,
    EV_APPENDED = 3'd3,
    EV_REPLACED = 3'd4,
    EV_FULL     = 3'd5
  } ev_kind_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] mask;
    logic [HELD_W-1:0]   held;
    logic                registered;
    logic                shift_off;
    logic                ctrl_off;
    logic                pressed;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic            mask_en;
    logic [IW-1:0]   idx;
    entry_t          data;
  } entry_wr_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [IW-1:0]     idx;
    logic [HELD_W-1:0] held;
  } result_t;

endpackage

FILE: rtl/key_combo_event_detector.sv
// Top level: request sequencer walking the entry table, result staging and config.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | req_type key_bits elapsed_ms combo_mask
//          |           |                      | shift_disables ctrl_disables
//  out     | output    | out_valid / out_ready| event_kind entry_index held_ms last
//  cfg     | input     | cfg_we (no wait)     | cfg_index cfg_data
//
// A scan runs from acceptance through a read issue, an evaluation of each entry (count
// entries, count is 16..32), an end check and the flush. A register request ends after
// its first matching mask; with no match it walks every entry and then appends the
// combination in the append state.
// A result leaves through a one-deep pending stage so that the final one can carry last;
// a stalled output holds the walk. rst (synchronous) clears all entry flags, drops the
// appended entries and sets the config registers to their defaults. in_ready is high only between requests.
module key_combo_event_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [kced_pkg::KEY_BITS-1:0]     key_bits,
  input  logic [kced_pkg::ELAPSED_W-1:0]    elapsed_ms,
  input  logic [kced_pkg::KEY_BITS-1:0]     combo_mask,
  input  logic                              shift_disables,
  input  logic                              ctrl_disables,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        event_kind,
  output logic [kced_pkg::IDX_OUT_W-1:0]    entry_index,
  output logic [kced_pkg::HELD_W-1:0]       held_ms,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic [kced_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [kced_pkg::CFG_W-1:0]        cfg_data
);
  import kced_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_APPEND = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

  state_t state, state_next;

  // config
  logic [KEY_BITS-1:0]  shift_mask;
  logic [KEY_BITS-1:0]  ctrl_mask;
  logic [ELAPSED_W-1:0] elapsed_limit;

  // latched request
  logic                 req_r;
  logic [KEY_BITS-1:0]  keys_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [KEY_BITS-1:0]  combo_r;
  logic                 sdis_r;
  logic                 cdis_r;
  logic                 shift_on_r;
  logic                 ctrl_on_r;

  // walk
  logic [CW-1:0] rd_cnt, rd_cnt_next;
  logic          ev_valid, ev_valid_next;
  logic [IW-1:0] ev_idx, ev_idx_next;
  logic [CW-1:0] count, count_next;
  logic          rd_en;
  entry_t        rd_data;
  entry_wr_t     wr;

  // result staging
  logic    pend_valid, pend_valid_next;
  result_t pend, pend_next;
  logic    out_valid_next;
  result_t out_res, out_res_next;
  logic    out_last, out_last_next;

  logic    in_accept;
  logic    out_free;
  logic    res_valid;
  result_t res;
  logic    stall;
  logic    key_hit;
  logic    suppressed;
  logic [HELD_W:0]   held_sum;
  logic [HELD_W-1:0] held_sat;

  kced_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_idx  (rd_cnt[IW-1:0]),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign key_hit    = ((keys_r & rd_data.mask) == rd_data.mask);
  assign suppressed = (shift_on_r && rd_data.shift_off) || (ctrl_on_r && rd_data.ctrl_off);
  assign held_sum   = {1'b0, rd_data.held} + (HELD_W + 1)'(elapsed_r);
  assign held_sat   = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];

  // entry evaluation and table update
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    wr        = '0;
    wr.idx    = ev_idx;
    wr.data   = rd_data;
    if (state == ST_WALK && ev_valid) begin
      if (req_r == REQ_SCAN) begin
        if (rd_data.registered) begin
          if (!suppressed && key_hit) begin
            res_valid = 1'b1;
            wr.en     = 1'b1;
            if (rd_data.pressed) begin
              wr.data.held = held_sat;
              res = '{kind: EV_HOLD, idx: ev_idx, held: held_sat};
            end else begin
              wr.data.pressed = 1'b1;
              wr.data.held    = '0;
              res = '{kind: EV_PRESS, idx: ev_idx, held: '0};
            end
          end else if (rd_data.pressed) begin
            res_valid       = 1'b1;
            wr.en           = 1'b1;
            wr.data.pressed = 1'b0;
            wr.data.held    = '0;
            res = '{kind: EV_RELEASE, idx: ev_idx, held: rd_data.held};
          end
        end
      end else if (rd_data.mask == combo_r) begin
        res_valid          = 1'b1;
        wr.en              = 1'b1;
        wr.data.registered = 1'b1;
        wr.data.shift_off  = sdis_r;
        wr.data.ctrl_off   = cdis_r;
        wr.data.pressed    = 1'b0;
        wr.data.held       = '0;
        res = '{kind: EV_REPLACED, idx: ev_idx, held: '0};
      end
    end else if (state == ST_APPEND) begin
      res_valid = 1'b1;
      if (count >= CW'(MAX_ENTRIES)) begin
        res = '{kind: EV_FULL, idx: '0, held: '0};
      end else begin
        wr.en              = 1'b1;
        wr.mask_en         = 1'b1;
        wr.idx             = count[IW-1:0];
        wr.data.mask       = combo_r;
        wr.data.held       = '0;
        wr.data.registered = 1'b1;
        wr.data.shift_off  = (|(combo_r & shift_mask)) ? 1'b0 : sdis_r;
        wr.data.ctrl_off   = (|(combo_r & ctrl_mask)) ? 1'b0 : cdis_r;
        wr.data.pressed    = 1'b0;
        res = '{kind: EV_APPENDED, idx: count[IW-1:0], held: '0};
      end
    end
    // a stalled entry is evaluated again later
    stall = res_valid && pend_valid && !out_free;
    if (stall) begin
      wr.en = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    rd_cnt_next     = rd_cnt;
    ev_valid_next   = ev_valid;
    ev_idx_next     = ev_idx;
    count_next      = count;
    rd_en           = 1'b0;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_res_next    = out_res;
    out_last_next   = out_last;
    out_valid_next  = out_valid && !out_ready;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          rd_cnt_next   = '0;
          ev_valid_next = 1'b0;
          state_next    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (res_valid) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_res_next   = pend;
              out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = res;
          end
          if (rd_cnt < count) begin
            rd_en         = 1'b1;
            ev_valid_next = 1'b1;
            ev_idx_next   = rd_cnt[IW-1:0];
            rd_cnt_next   = rd_cnt + CW'(1);
          end else begin
            ev_valid_next = 1'b0;
          end
          if (req_r == REQ_REGISTER && res_valid) begin
            ev_valid_next = 1'b0;
            state_next    = ST_FLUSH;
          end else if (!ev_valid && rd_cnt >= count) begin
            state_next = (req_r == REQ_SCAN) ? ST_FLUSH : ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        pend_valid_next = 1'b1;
        pend_next       = res;
        if (wr.en) begin
          count_next = count + CW'(1);
        end
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_res_next    = pend;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ev_valid   <= 1'b0;
      rd_cnt     <= '0;
      count      <= CW'(KEY_BITS);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ev_valid   <= ev_valid_next;
      rd_cnt     <= rd_cnt_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx   <= ev_idx_next;
    pend     <= pend_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
    if (in_accept) begin
      req_r      <= req_type;
      keys_r     <= key_bits;
      elapsed_r  <= (elapsed_ms > elapsed_limit) ? '0 : elapsed_ms;
      combo_r    <= combo_mask;
      sdis_r     <= shift_disables;
      cdis_r     <= ctrl_disables;
      shift_on_r <= ((key_bits & shift_mask) == shift_mask);
      ctrl_on_r  <= ((key_bits & ctrl_mask) == ctrl_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_mask    <= SHIFT_MASK_RST;
      ctrl_mask     <= CTRL_MASK_RST;
      elapsed_limit <= ELAPSED_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_MASK:    shift_mask    <= cfg_data;
        REG_CTRL_MASK:     ctrl_mask     <= cfg_data;
        REG_ELAPSED_LIMIT: elapsed_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign event_kind  = out_res.kind;
  assign entry_index = out_res.idx[IDX_OUT_W-1:0];
  assign held_ms     = out_res.held;
  assign last        = out_last;

`ifndef ASSERT_OFF
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("pending result left over between requests");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND && count < CW'(MAX_ENTRIES)) |=> count == $past(count) + CW'(1))
    else $error("append did not advance the entry count");

  a_register_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_APPENDED || event_kind == EV_REPLACED ||
                   event_kind == EV_FULL)) |-> last)
    else $error("register result not marked last");

  a_stall_holds_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && stall) |=> ($stable(rd_cnt) && ev_valid))
    else $error("walk advanced while the result path was stalled");
`endif

endmodule

FILE: rtl/kced_store.sv
// Entry table: combination masks, hold times and per-entry flags, one read port.
module kced_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [kced_pkg::IW-1:0] rd_idx,
  output kced_pkg::entry_t    rd_data,
  input  kced_pkg::entry_wr_t wr
);
  import kced_pkg::*;

  // single-key slots have fixed masks; only the masks of appended entries are stored
  logic [KEY_BITS-1:0] mask_mem [XDEPTH];
  logic [HELD_W-1:0]   held_mem [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] registered;
  logic [MAX_ENTRIES-1:0] shift_off;
  logic [MAX_ENTRIES-1:0] ctrl_off;
  logic [MAX_ENTRIES-1:0] pressed;

  logic [IW-1:0] rd_ext;
  logic [IW-1:0] wr_ext;

  assign rd_ext = rd_idx - IW'(KEY_BITS);
  assign wr_ext = wr.idx - IW'(KEY_BITS);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      held_mem[wr.idx] <= wr.data.held;
    end
    if (wr.en && wr.mask_en) begin
      mask_mem[wr_ext[XW-1:0]] <= wr.data.mask;
    end
    if (rd_en) begin
      rd_data.held       <= held_mem[rd_idx];
      rd_data.registered <= registered[rd_idx];
      rd_data.shift_off  <= shift_off[rd_idx];
      rd_data.ctrl_off   <= ctrl_off[rd_idx];
      rd_data.pressed    <= pressed[rd_idx];
      if (rd_idx < IW'(KEY_BITS)) begin
        rd_data.mask <= KEY_BITS'(1) << rd_idx;
      end else begin
        rd_data.mask <= mask_mem[rd_ext[XW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= '0;
      shift_off  <= '0;
      ctrl_off   <= '0;
      pressed    <= '0;
    end else if (wr.en) begin
      registered[wr.idx] <= wr.data.registered;
      shift_off[wr.idx]  <= wr.data.shift_off;
      ctrl_off[wr.idx]   <= wr.data.ctrl_off;
      pressed[wr.idx]    <= wr.data.pressed;
    end
  end

endmodule

FILE: tb/tb_key_combo_event_detector.sv
// Self-checking testbench for key_combo_event_detector: directed and random traffic.
`timescale 1ns / 100ps

module tb_key_combo_event_detector;
  import kced_pkg::*;

  localparam int DRAIN_CYCLES  = 100000;
  localparam int SETTLE_CYCLES = 64;
  localparam int CHUNK_ITEMS   = 24;
  localparam int RANDOM_CHUNKS = 7;

  typedef struct {
    logic                 req_type;
    logic [KEY_BITS-1:0]  keys;
    logic [ELAPSED_W-1:0] elapsed;
    logic [KEY_BITS-1:0]  combo;
    logic                 sdis;
    logic                 cdis;
  } key_req_t;

  typedef struct {
    ev_kind_t             kind;
    logic [IDX_OUT_W-1:0] idx;
    logic [HELD_W-1:0]    held;
    logic                 last;
  } key_event_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = 1'b0;
  logic [KEY_BITS-1:0]  key_bits = '0;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic [KEY_BITS-1:0]  combo_mask = '0;
  logic                 shift_disables = 1'b0;
  logic                 ctrl_disables = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           event_kind;
  logic [IDX_OUT_W-1:0] entry_index;
  logic [HELD_W-1:0]    held_ms;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IW-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // mirror of the entry table and config registers
  logic [KEY_BITS-1:0]  tbl_mask [MAX_ENTRIES];
  bit                   tbl_registered [MAX_ENTRIES];
  bit                   tbl_shift_off [MAX_ENTRIES];
  bit                   tbl_ctrl_off [MAX_ENTRIES];
  bit                   tbl_pressed [MAX_ENTRIES];
  logic [HELD_W-1:0]    tbl_held [MAX_ENTRIES];
  int unsigned          tbl_count;
  logic [KEY_BITS-1:0]  cur_shift;
  logic [KEY_BITS-1:0]  cur_ctrl;
  logic [ELAPSED_W-1:0] cur_limit;

  logic [KEY_BITS-1:0]  scan_keys = '0;   // keys kept down across ticks
  key_event_t           pending_events[$];
  int                   errors = 0;
  bit                   no_idle = 1'b0;

  key_combo_event_detector dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .key_bits       (key_bits),
    .elapsed_ms     (elapsed_ms),
    .combo_mask     (combo_mask),
    .shift_disables (shift_disables),
    .ctrl_disables  (ctrl_disables),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .entry_index    (entry_index),
    .held_ms        (held_ms),
    .last           (last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // expected events for one accepted transaction; updates the mirror
  function automatic void predict_events(input key_req_t r);
    key_event_t           ev;
    key_event_t           evs[$];
    int                   hit;
    logic [ELAPSED_W-1:0] el;
    logic [HELD_W:0]      sum;
    bit                   shift_on;
    bit                   ctrl_on;
    bit                   supp;
    hit = -1;
    ev.held = '0;
    ev.last = 1'b0;
    if (r.req_type == REQ_REGISTER) begin
      for (int i = 0; i < tbl_count; i++)
        if (hit < 0 && tbl_mask[i] == r.combo) hit = i;
      ev.last = 1'b1;
      if (hit >= 0) begin
        tbl_registered[hit] = 1'b1;
        tbl_shift_off[hit]  = r.sdis;
        tbl_ctrl_off[hit]   = r.cdis;
        tbl_pressed[hit]    = 1'b0;
        tbl_held[hit]       = '0;
        ev.kind = EV_REPLACED;
        ev.idx  = IDX_OUT_W'(hit);
      end else if (tbl_count >= MAX_ENTRIES) begin
        ev.kind = EV_FULL;
        ev.idx  = '0;
      end else begin
        tbl_mask[tbl_count]       = r.combo;
        tbl_registered[tbl_count] = 1'b1;
        tbl_shift_off[tbl_count]  = ((r.combo & cur_shift) != 0) ? 1'b0 : r.sdis;
        tbl_ctrl_off[tbl_count]   = ((r.combo & cur_ctrl) != 0) ? 1'b0 : r.cdis;
        tbl_pressed[tbl_count]    = 1'b0;
        tbl_held[tbl_count]       = '0;
        ev.kind = EV_APPENDED;
        ev.idx  = IDX_OUT_W'(tbl_count);
        tbl_count++;
      end
      pending_events = {pending_events, ev};
    end else begin
      shift_on = (r.keys & cur_shift) == cur_shift;
      ctrl_on  = (r.keys & cur_ctrl) == cur_ctrl;
      el = (r.elapsed > cur_limit) ? '0 : r.elapsed;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_registered[i]) begin
          supp = (shift_on && tbl_shift_off[i]) || (ctrl_on && tbl_ctrl_off[i]);
          ev.idx = IDX_OUT_W'(i);
          if (!supp && (r.keys & tbl_mask[i]) == tbl_mask[i]) begin
            if (tbl_pressed[i]) begin
              sum = {1'b0, tbl_held[i]} + (HELD_W + 1)'(el);
              tbl_held[i] = sum[HELD_W] ? '1 : sum[HELD_W-1:0];
              ev.kind = EV_HOLD;
              ev.held = tbl_held[i];
            end else begin
              tbl_pressed[i] = 1'b1;
              tbl_held[i]    = '0;
              ev.kind = EV_PRESS;
              ev.held = '0;
            end
            evs = {evs, ev};
          end else if (tbl_pressed[i]) begin
            ev.kind = EV_RELEASE;
            ev.held = tbl_held[i];
            evs = {evs, ev};
            tbl_pressed[i] = 1'b0;
            tbl_held[i]    = '0;
          end
        end
      end
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      pending_events = {pending_events, evs};
    end
  endfunction

  function automatic key_req_t scan_req(input logic [KEY_BITS-1:0] keys,
                                        input logic [ELAPSED_W-1:0] elapsed);
    key_req_t r;
    r.req_type = REQ_SCAN;
    r.keys     = keys;
    r.elapsed  = elapsed;
    r.combo    = 16'($urandom);
    r.sdis     = 1'($urandom);
    r.cdis     = 1'($urandom);
    return r;
  endfunction

  function automatic key_req_t register_req(input logic [KEY_BITS-1:0] combo,
                                            input logic sdis, input logic cdis);
    key_req_t r;
    r.req_type = REQ_REGISTER;
    r.keys     = 16'($urandom);
    r.elapsed  = 16'($urandom);
    r.combo    = combo;
    r.sdis     = sdis;
    r.cdis     = cdis;
    return r;
  endfunction

  // mostly ticks whose keys evolve slowly, so presses turn into holds
  function automatic key_req_t random_request();
    logic [ELAPSED_W-1:0] e;
    logic [KEY_BITS-1:0]  c;
    int                   k;
    int                   sel;
    if ($urandom_range(0, 9) < 3) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 19);
      if (sel < 45)      c = 16'h0001 << $urandom_range(0, 15);
      else if (sel < 85) c = (k < 15) ? (16'h0003 << k) : (16'h0101 << (k - 15));
      else               c = 16'($urandom);
      return register_req(c, 1'($urandom), 1'($urandom));
    end
    case ($urandom_range(0, 11))
      0:       scan_keys = '0;
      1:       scan_keys = 16'($urandom);
      2:       scan_keys = 16'hFFFF;
      3, 4, 5: scan_keys |= tbl_mask[$urandom_range(0, tbl_count - 1)];
      6:       scan_keys &= ~(16'h0001 << $urandom_range(0, 15));
      7:       scan_keys ^= cur_shift;
      8:       scan_keys ^= cur_ctrl;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       e = '0;
      1:       e = 16'hFFFF;
      2:       e = cur_limit;
      3:       e = cur_limit + 16'd1;
      4:       e = 16'($urandom);
      default: e = 16'($urandom_range(0, 600));
    endcase
    return scan_req(scan_keys, e);
  endfunction

  task automatic send_request(input key_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= r.req_type;
    key_bits       <= r.keys;
    elapsed_ms     <= r.elapsed;
    combo_mask     <= r.combo;
    shift_disables <= r.sdis;
    ctrl_disables  <= r.cdis;
    do @(posedge clk); while (!in_ready);
    predict_events(r);
  endtask

  // drain outstanding events, then let a silent scan finish its walk
  task automatic wait_idle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_events.size() != 0 && n < DRAIN_CYCLES) begin
      @(posedge clk);
      n++;
    end
    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      errors++;
      pending_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] shift_m, input logic [CFG_W-1:0] ctrl_m,
                            input logic [CFG_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHIFT_MASK;
    cfg_data  <= shift_m;
    @(posedge clk);
    cfg_index <= REG_CTRL_MASK;
    cfg_data  <= ctrl_m;
    @(posedge clk);
    cfg_index <= REG_ELAPSED_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_shift = shift_m;
    cur_ctrl  = ctrl_m;
    cur_limit = limit;
  endtask

  task automatic test_reset();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tbl_mask[i]       = (i < KEY_BITS) ? (16'h0001 << i) : '0;
      tbl_registered[i] = 1'b0;
      tbl_shift_off[i]  = 1'b0;
      tbl_ctrl_off[i]   = 1'b0;
      tbl_pressed[i]    = 1'b0;
      tbl_held[i]       = '0;
    end
    tbl_count = KEY_BITS;
    cur_shift = SHIFT_MASK_RST;
    cur_ctrl  = CTRL_MASK_RST;
    cur_limit = ELAPSED_LIMIT_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // reset config: slot replacement, appends, flag clearing, empty combo
  task automatic test_register();
    send_request(scan_req(16'hFFFF, 16'd10));          // nothing registered yet
    send_request(register_req(16'h0001, 1'b0, 1'b0));
    send_request(register_req(16'h8000, 1'b1, 1'b1));
    send_request(register_req(16'h0030, 1'b1, 1'b1));  // holds shift and ctrl
    send_request(register_req(16'h0000, 1'b1, 1'b0));
    send_request(register_req(16'h0003, 1'b1, 1'b0));
    send_request(register_req(16'h0F0F, 1'b0, 1'b1));
  endtask

  task automatic test_scan();
    send_request(scan_req(16'h0001, 16'd0));
    send_request(scan_req(16'h0003, 16'd100));
    send_request(scan_req(16'h0013, 16'd700));         // shift down, over the limit
    send_request(scan_req(16'h0F3F, 16'd500));
    send_request(scan_req(16'hFFFF, 16'd501));
    send_request(scan_req(16'h0000, 16'hFFFF));
    send_request(register_req(16'h0003, 1'b0, 1'b0));
    send_request(register_req(16'h0001, 1'b1, 1'b0));
  endtask

  task automatic test_config_extremes();
    wait_idle();
    set_config(16'h0000, 16'h0000, 16'h0000);          // shift and ctrl always held
    send_request(scan_req(16'h0F0F, 16'd1));
    send_request(scan_req(16'h0F0F, 16'd0));
    send_request(scan_req(16'h0000, 16'd0));
    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(register_req(16'h00F0, 1'b1, 1'b1));
    send_request(register_req(16'h0000, 1'b0, 1'b1));
    send_request(scan_req(16'hFFFF, 16'hFFFF));
    send_request(scan_req(16'hFFFF, 16'hFFFF));
    send_request(scan_req(16'h7FFF, 16'hFFFF));
    send_request(scan_req(16'h0000, 16'hFFFF));
  endtask

  task automatic test_random_traffic();
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      wait_idle();
      case (c % 6)
        0: set_config(SHIFT_MASK_RST, CTRL_MASK_RST, ELAPSED_LIMIT_RST);
        1: set_config(16'h0000, 16'h0000, 16'h0000);
        2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_config(16'h0001 << $urandom_range(0, 15), 16'h0001 << $urandom_range(0, 15),
                      16'($urandom_range(0, 1000)));
        4: set_config(16'h0003 << $urandom_range(0, 14), 16'h0005 << $urandom_range(0, 13),
                      16'($urandom_range(50, 600)));
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      no_idle = (c == 2);
      repeat (CHUNK_ITEMS) send_request(random_request());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_table_full();
    logic [KEY_BITS-1:0] c;
    bit                  known;
    for (int n = 0; n <= MAX_ENTRIES - KEY_BITS; n++) begin
      do begin
        c = 16'($urandom);
        known = 1'b0;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_mask[i] == c) known = 1'b1;
      end while (known);
      send_request(register_req(c, 1'($urandom), 1'($urandom)));
    end
    // table is full now: replacement still works
    send_request(register_req(tbl_mask[MAX_ENTRIES - 1], 1'b0, 1'b0));
    send_request(scan_req(16'hFFFF, 16'd20));
    send_request(scan_req(16'hFFFF, 16'd20));
    send_request(scan_req(16'h0000, 16'd20));
  endtask

  initial begin : drive_out_ready
    int run;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      run = $urandom_range(1, 8);
      gap = pick_gap();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    key_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_kind %0d entry_index %0d held_ms %0d last %0d",
               event_kind, entry_index, held_ms, last);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          errors++;
        end
        if (entry_index !== want.idx) begin
          $error("entry_index: expected %0d, got %0d", want.idx, entry_index);
          errors++;
        end
        if (held_ms !== want.held) begin
          $error("held_ms: expected %0d, got %0d", want.held, held_ms);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    test_reset();
    test_register();
    test_scan();
    test_config_extremes();
    test_random_traffic();
    test_table_full();
    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
